// File: rtl/core/top_k_ranked_insert_table_defines.svh
// Assertion macros shared by the ranked insert table RTL.
`ifndef TOP_K_RANKED_INSERT_TABLE_DEFINES_SVH
`define TOP_K_RANKED_INSERT_TABLE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define TKRI_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define TKRI_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: rtl/core/tkri_pkg.sv
// Shared constants and controller command types for the ranked insert table.
package tkri_pkg;

	localparam int TABLE_DEPTH_DEF = 8;

	localparam int SCORE_W  = 32;
	localparam int DUR_W    = 32;
	localparam int RETRY_W  = 8;
	localparam int INDEX_W  = 3;
	localparam int RANK_W   = 3;
	localparam int COUNT_W  = 4;

	localparam logic ACT_SUBMIT = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic compare;
		logic commit;
	} tkri_cmd_t;

endpackage

// File: rtl/core/top_k_ranked_insert_table.sv
// Top level of the ranked insert table: controller, datapath and checks.
//
// Input channel (in_valid/in_ready) carries one request: action 0 submits an
// entry (score, duration_sec, retries), action 1 reads the entry at
// read_index. Output channel (out_valid/out_ready) returns one result per
// request: accepted and insert_rank for a submit, read_valid and read data
// for a read, and entry_count after the request in both cases.
// Entries stay sorted best first: higher score, then lower duration, then
// lower retries. Ties go after entries already stored.
// Each request runs three controller steps: capture registers the request,
// compare registers a parallel compare against all cells, and commit does
// the priority select and insert shift and loads the result register, which
// raises out_valid. A new request is taken only once the previous one has
// committed, so requests never overlap in the controller sequence.
// The result register lets the next request be accepted while a result
// waits; if the receiver stalls, the commit step holds until the register
// frees, and in_ready stays low until then.
// Reset empties the table (fill count 0) and clears out_valid; the result register is not reset.
`include "top_k_ranked_insert_table_defines.svh"

module top_k_ranked_insert_table #(
	parameter int TABLE_DEPTH = tkri_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [tkri_pkg::SCORE_W-1:0]  score,
	input  logic [tkri_pkg::DUR_W-1:0]    duration_sec,
	input  logic [tkri_pkg::RETRY_W-1:0]  retries,
	input  logic [tkri_pkg::INDEX_W-1:0]  read_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          accepted,
	output logic [tkri_pkg::RANK_W-1:0]   insert_rank,
	output logic [tkri_pkg::COUNT_W-1:0]  entry_count,
	output logic                          read_valid,
	output logic [tkri_pkg::SCORE_W-1:0]  read_score,
	output logic [tkri_pkg::DUR_W-1:0]    read_duration,
	output logic [tkri_pkg::RETRY_W-1:0]  read_retries
);

	tkri_pkg::tkri_cmd_t cmd;

	tkri_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	tkri_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.action        (action),
		.score         (score),
		.duration_sec  (duration_sec),
		.retries       (retries),
		.read_index    (read_index),
		.accepted      (accepted),
		.insert_rank   (insert_rank),
		.entry_count   (entry_count),
		.read_valid    (read_valid),
		.read_score    (read_score),
		.read_duration (read_duration),
		.read_retries  (read_retries)
	);

	// An accepted request is compared in the very next cycle
	`TKRI_ASSERT_NEXT(a_capture_then_compare, clk, arst_n, in_valid && in_ready, cmd.compare && !in_ready, "compare step did not follow capture")
	// A result never both inserts and returns read data
	`TKRI_ASSERT_IMP(a_submit_or_read, clk, arst_n, out_valid, !(accepted && read_valid), "result flags both insert and read")
	// An insert always leaves at least one entry
	`TKRI_ASSERT_IMP(a_insert_nonempty, clk, arst_n, out_valid && accepted, entry_count != '0, "insert reported with empty table")

endmodule

// File: rtl/core/tkri_ctrl.sv
// Controller sequencing capture, compare and commit steps for each request.
module tkri_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output tkri_pkg::tkri_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	// Decode commands from the current state
	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		cmd.capture = in_valid && in_ready;
		cmd.compare = (state_q == ST_CMP);
		cmd.commit  = (state_q == ST_UPD) && (!out_valid_q || out_ready);
	end

	// Advance the sequence; hold in update while the output register is full
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.capture) state_d = ST_CMP;
			end
			ST_CMP: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (cmd.commit) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/core/tkri_datapath.sv
// Sorted entry cells, parallel rank compare, insert shift and result register.
module tkri_datapath #(
	parameter int TABLE_DEPTH = tkri_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tkri_pkg::tkri_cmd_t           cmd,
	input  logic                          action,
	input  logic [tkri_pkg::SCORE_W-1:0]  score,
	input  logic [tkri_pkg::DUR_W-1:0]    duration_sec,
	input  logic [tkri_pkg::RETRY_W-1:0]  retries,
	input  logic [tkri_pkg::INDEX_W-1:0]  read_index,
	output logic                          accepted,
	output logic [tkri_pkg::RANK_W-1:0]   insert_rank,
	output logic [tkri_pkg::COUNT_W-1:0]  entry_count,
	output logic                          read_valid,
	output logic [tkri_pkg::SCORE_W-1:0]  read_score,
	output logic [tkri_pkg::DUR_W-1:0]    read_duration,
	output logic [tkri_pkg::RETRY_W-1:0]  read_retries
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > tkri_pkg::INDEX_W) ? CNT_W : tkri_pkg::INDEX_W;

	// Captured request
	logic                          act_s1;
	logic [tkri_pkg::SCORE_W-1:0]  score_s1;
	logic [tkri_pkg::DUR_W-1:0]    dur_s1;
	logic [tkri_pkg::RETRY_W-1:0]  ret_s1;
	logic [tkri_pkg::INDEX_W-1:0]  idx_s1;

	// Compare result, one bit per valid cell
	logic [TABLE_DEPTH-1:0]        beats_s2;

	// Entry cells and fill count
	logic [tkri_pkg::SCORE_W-1:0]  cell_score_q [TABLE_DEPTH];
	logic [tkri_pkg::DUR_W-1:0]    cell_dur_q   [TABLE_DEPTH];
	logic [tkri_pkg::RETRY_W-1:0]  cell_ret_q   [TABLE_DEPTH];
	logic [CNT_W-1:0]              count_q;

	// Result register
	logic                          accepted_q;
	logic [tkri_pkg::RANK_W-1:0]   rank_q;
	logic [tkri_pkg::COUNT_W-1:0]  entry_count_q;
	logic                          read_valid_q;
	logic [tkri_pkg::SCORE_W-1:0]  read_score_q;
	logic [tkri_pkg::DUR_W-1:0]    read_dur_q;
	logic [tkri_pkg::RETRY_W-1:0]  read_ret_q;

	logic [TABLE_DEPTH-1:0]        beats_d;
	logic                          hit;
	logic [CNT_W-1:0]              pos;
	logic [tkri_pkg::RANK_W-1:0]   pos_rank;
	logic                          full;
	logic                          do_insert;
	logic [CMP_W-1:0]              idx_ext;
	logic                          rd_ok;
	logic [tkri_pkg::SCORE_W-1:0]  rd_score;
	logic [tkri_pkg::DUR_W-1:0]    rd_dur;
	logic [tkri_pkg::RETRY_W-1:0]  rd_ret;

	// Compare the new entry against every valid cell
	always_comb begin
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			beats_d[k] = (CNT_W'(k) < count_q) &&
				((score_s1 > cell_score_q[k]) ||
				 ((score_s1 == cell_score_q[k]) &&
				  ((dur_s1 < cell_dur_q[k]) ||
				   ((dur_s1 == cell_dur_q[k]) && (ret_s1 < cell_ret_q[k])))));
		end
	end

	// Pick the first outranked cell, else the end of the table
	always_comb begin
		hit      = 1'b0;
		pos      = count_q;
		pos_rank = tkri_pkg::RANK_W'(count_q);
		for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
			if (beats_s2[k]) begin
				hit      = 1'b1;
				pos      = CNT_W'(k);
				pos_rank = tkri_pkg::RANK_W'(k);
			end
		end
		full      = (count_q == CNT_W'(TABLE_DEPTH));
		do_insert = (act_s1 == tkri_pkg::ACT_SUBMIT) && (hit || !full);
	end

	// Select the cell at the read index
	always_comb begin
		idx_ext  = CMP_W'(idx_s1);
		rd_ok    = (act_s1 == tkri_pkg::ACT_READ) &&
			(idx_ext < CMP_W'(count_q)) && (idx_ext < CMP_W'(TABLE_DEPTH));
		rd_score = '0;
		rd_dur   = '0;
		rd_ret   = '0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			if (rd_ok && (idx_ext == CMP_W'(k))) begin
				rd_score = cell_score_q[k];
				rd_dur   = cell_dur_q[k];
				rd_ret   = cell_ret_q[k];
			end
		end
	end

	// Capture the request and the compare vector
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_s1   <= action;
			score_s1 <= score;
			dur_s1   <= duration_sec;
			ret_s1   <= retries;
			idx_s1   <= read_index;
		end
		if (cmd.compare) begin
			beats_s2 <= beats_d;
		end
	end

	// Shift cells down from the insert position and drop the last when full
	always_ff @(posedge clk) begin
		if (cmd.commit && do_insert) begin
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				if (CNT_W'(k) == pos) begin
					cell_score_q[k] <= score_s1;
					cell_dur_q[k]   <= dur_s1;
					cell_ret_q[k]   <= ret_s1;
				end else if ((k > 0) && (CNT_W'(k) > pos)) begin
					cell_score_q[k] <= cell_score_q[(k > 0) ? k - 1 : 0];
					cell_dur_q[k]   <= cell_dur_q[(k > 0) ? k - 1 : 0];
					cell_ret_q[k]   <= cell_ret_q[(k > 0) ? k - 1 : 0];
				end
			end
		end
	end

	// Track the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit && do_insert && !full) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			accepted_q    <= do_insert;
			rank_q        <= do_insert ? pos_rank : '0;
			entry_count_q <= tkri_pkg::COUNT_W'((do_insert && !full) ?
				count_q + CNT_W'(1) : count_q);
			read_valid_q  <= rd_ok;
			read_score_q  <= rd_score;
			read_dur_q    <= rd_dur;
			read_ret_q    <= rd_ret;
		end
	end

	assign accepted      = accepted_q;
	assign insert_rank   = rank_q;
	assign entry_count   = entry_count_q;
	assign read_valid    = read_valid_q;
	assign read_score    = read_score_q;
	assign read_duration = read_dur_q;
	assign read_retries  = read_ret_q;

endmodule

// File: tb/sv/top_k_ranked_insert_table_tb.sv
// Testbench for the ranked insert table: directed and random requests checked against a predictor.
module top_k_ranked_insert_table_tb;

	localparam int DEPTH         = tkri_pkg::TABLE_DEPTH_DEF;
	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 10;
	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 12;

	typedef struct packed {
		logic                           action;
		logic [tkri_pkg::SCORE_W-1:0]   score;
		logic [tkri_pkg::DUR_W-1:0]     duration;
		logic [tkri_pkg::RETRY_W-1:0]   retries;
		logic [tkri_pkg::INDEX_W-1:0]   index;
	} table_request_t;

	typedef struct packed {
		logic                           accepted;
		logic [tkri_pkg::RANK_W-1:0]    rank;
		logic [tkri_pkg::COUNT_W-1:0]   count;
		logic                           read_valid;
		logic [tkri_pkg::SCORE_W-1:0]   read_score;
		logic [tkri_pkg::DUR_W-1:0]     read_duration;
		logic [tkri_pkg::RETRY_W-1:0]   read_retries;
	} table_result_t;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	logic                            action;
	logic [tkri_pkg::SCORE_W-1:0]    score;
	logic [tkri_pkg::DUR_W-1:0]      duration_sec;
	logic [tkri_pkg::RETRY_W-1:0]    retries;
	logic [tkri_pkg::INDEX_W-1:0]    read_index;
	logic                            out_valid;
	logic                            out_ready;
	logic                            accepted;
	logic [tkri_pkg::RANK_W-1:0]     insert_rank;
	logic [tkri_pkg::COUNT_W-1:0]    entry_count;
	logic                            read_valid;
	logic [tkri_pkg::SCORE_W-1:0]    read_score;
	logic [tkri_pkg::DUR_W-1:0]      read_duration;
	logic [tkri_pkg::RETRY_W-1:0]    read_retries;

	// Predicted table contents, best entry first
	logic [tkri_pkg::SCORE_W-1:0]    ranked_score [DEPTH];
	logic [tkri_pkg::DUR_W-1:0]      ranked_duration [DEPTH];
	logic [tkri_pkg::RETRY_W-1:0]    ranked_retries [DEPTH];
	int                              ranked_count = 0;

	table_result_t         expected_results [$];
	int                    error_count = 0;
	int                    quiet_cycles = 0;
	int unsigned           sender_idle_pct = 0;
	int unsigned           receiver_stall_pct = 0;

	top_k_ranked_insert_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.score         (score),
		.duration_sec  (duration_sec),
		.retries       (retries),
		.read_index    (read_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.accepted      (accepted),
		.insert_rank   (insert_rank),
		.entry_count   (entry_count),
		.read_valid    (read_valid),
		.read_score    (read_score),
		.read_duration (read_duration),
		.read_retries  (read_retries)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// True if the request's entry strictly outranks the stored entry at k
	function automatic logic outranks(input table_request_t req, input int k);
		if (req.score != ranked_score[k])
			return req.score > ranked_score[k];
		if (req.duration != ranked_duration[k])
			return req.duration < ranked_duration[k];
		return req.retries < ranked_retries[k];
	endfunction

	// Apply one request to the predicted table and return its result
	function automatic table_result_t update_ranking(input table_request_t req);
		table_result_t res;
		int pos;
		int last;
		res = '0;
		if (req.action == tkri_pkg::ACT_SUBMIT) begin
			pos = ranked_count;
			for (int k = ranked_count - 1; k >= 0; k--)
				if (outranks(req, k))
					pos = k;
			if (pos < DEPTH) begin
				// shift worse entries down, drop the last one when full
				last = (ranked_count < DEPTH) ? ranked_count : DEPTH - 1;
				for (int k = last; k > pos; k--) begin
					ranked_score[k]    = ranked_score[k - 1];
					ranked_duration[k] = ranked_duration[k - 1];
					ranked_retries[k]  = ranked_retries[k - 1];
				end
				ranked_score[pos]    = req.score;
				ranked_duration[pos] = req.duration;
				ranked_retries[pos]  = req.retries;
				if (ranked_count < DEPTH)
					ranked_count++;
				res.accepted = 1'b1;
				res.rank     = pos[tkri_pkg::RANK_W-1:0];
			end
		end else if (req.index < ranked_count) begin
			res.read_valid    = 1'b1;
			res.read_score    = ranked_score[req.index];
			res.read_duration = ranked_duration[req.index];
			res.read_retries  = ranked_retries[req.index];
		end
		res.count = ranked_count[tkri_pkg::COUNT_W-1:0];
		return res;
	endfunction

	function automatic table_request_t entry_request(input int s, input int d, input int r);
		table_request_t req;
		req = '{action: tkri_pkg::ACT_SUBMIT, score: s[tkri_pkg::SCORE_W-1:0],
			duration: d[tkri_pkg::DUR_W-1:0], retries: r[tkri_pkg::RETRY_W-1:0],
			index: '0};
		return req;
	endfunction

	function automatic table_request_t read_request(input int idx);
		table_request_t req;
		req = '{action: tkri_pkg::ACT_READ, score: '0, duration: '0, retries: '0,
			index: idx[tkri_pkg::INDEX_W-1:0]};
		return req;
	endfunction

	// Build a random request, mostly submits that land near stored entries
	function automatic table_request_t random_request();
		table_request_t req;
		int k;
		req.action   = ($urandom_range(99) < 25) ? tkri_pkg::ACT_READ : tkri_pkg::ACT_SUBMIT;
		req.score    = $urandom;
		req.duration = $urandom;
		req.retries  = tkri_pkg::RETRY_W'($urandom_range(255));
		req.index    = tkri_pkg::INDEX_W'($urandom_range(DEPTH - 1));
		if (req.action == tkri_pkg::ACT_SUBMIT) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					// keep the fully random keys
				end
				3, 4, 5, 6: begin
					// copy a stored entry and nudge one key to hit ties and mid-table ranks
					if (ranked_count > 0) begin
						k = $urandom_range(ranked_count - 1);
						req.score    = ranked_score[k];
						req.duration = ranked_duration[k];
						req.retries  = ranked_retries[k];
						case ($urandom_range(6))
							0: req.score    = req.score + 32'd1;
							1: req.score    = req.score - 32'd1;
							2: req.duration = req.duration + 32'd1;
							3: req.duration = req.duration - 32'd1;
							4: req.retries  = req.retries + 8'd1;
							5: req.retries  = req.retries - 8'd1;
							default: begin
							end
						endcase
					end
				end
				default: begin
					// crowd the keys into narrow ranges for frequent ties
					req.score    = $urandom_range(7);
					req.duration = $urandom_range(7);
					req.retries  = tkri_pkg::RETRY_W'($urandom_range(3));
				end
			endcase
		end
		return req;
	endfunction

	// Drive one request, hold it until taken, then record its expected result
	task automatic send_request(input table_request_t req);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= req.action;
		score        <= req.score;
		duration_sec <= req.duration;
		retries      <= req.retries;
		read_index   <= req.index;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_results.push_back(update_ranking(req));
	endtask

	// Hold off new requests until every result is back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endtask

	// Compare each result with the oldest expectation
	always @(posedge clk) begin : result_check
		table_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result arrived with no request pending");
				error_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("accepted", 32'(want.accepted), 32'(accepted));
				check_field("insert_rank", 32'(want.rank), 32'(insert_rank));
				check_field("entry_count", 32'(want.count), 32'(entry_count));
				check_field("read_valid", 32'(want.read_valid), 32'(read_valid));
				check_field("read_score", want.read_score, read_score);
				check_field("read_duration", want.read_duration, read_duration);
				check_field("read_retries", 32'(want.read_retries), 32'(read_retries));
			end
		end
	end

	// Stall the result channel at random
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);

	// End the run when no handshake happens for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Read both ends of the index range while the table is empty
	task automatic test_empty_reads();
		send_request(read_request(0));
		send_request(read_request(DEPTH - 1));
	endtask

	// Exercise each key, ties and both extremes while filling the table
	task automatic test_rank_order();
		send_request(entry_request(100, 50, 3));
		send_request(entry_request(100, 50, 3));
		send_request(entry_request(100, 49, 3));
		send_request(entry_request(100, 50, 2));
		send_request(entry_request('1, '1, '1));
		send_request(entry_request(0, 0, 0));
		send_request(entry_request(0, 0, 0));
		send_request(entry_request(0, 0, 1));
	endtask

	// Reject entries that outrank nothing; drop the last entry on insert
	task automatic test_full_table();
		send_request(entry_request(0, 0, '1));
		send_request(entry_request(0, 0, 1));
		send_request(entry_request(1, '1, '1));
		send_request(entry_request('1, 0, 0));
	endtask

	task automatic test_read_back();
		for (int i = 0; i < DEPTH; i++)
			send_request(read_request(i));
	endtask

	// Random requests under one idling pattern, drained at the end
	task automatic test_random_traffic(input int unsigned idle_pct,
			input int unsigned stall_pct, input int count);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		for (int i = 0; i < count; i++)
			send_request(random_request());
		wait_for_results();
	endtask

	initial begin
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		action       <= tkri_pkg::ACT_SUBMIT;
		score        <= '0;
		duration_sec <= '0;
		retries      <= '0;
		read_index   <= '0;
		out_ready    <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_reads();
		test_rank_order();
		test_full_table();
		test_read_back();
		wait_for_results();

		test_random_traffic(0, 0, 140);
		test_random_traffic(66, 0, 135);
		test_random_traffic(0, 66, 135);
		test_random_traffic(16, 16, 140);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: top_k_ranked_insert_table.f
+incdir+rtl/core
rtl/core/tkri_pkg.sv
rtl/core/tkri_ctrl.sv
rtl/core/tkri_datapath.sv
rtl/core/top_k_ranked_insert_table.sv
tb/sv/top_k_ranked_insert_table_tb.sv
